// ===== hdl/ssm_pkg.sv =====
// Shared constants, types and helpers for the satellite set summary block.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps
package ssm_pkg;

  localparam int MAX_SAT = 64;
  localparam int IDX_W   = $clog2(MAX_SAT);
  localparam int CNT_W   = $clog2(MAX_SAT + 1);
  localparam int SIG_W   = 7;
  localparam int BIT_W   = $clog2(SIG_W);
  localparam int TALLY_W = 7;
  localparam int ELEV_W  = 15;
  localparam int SNR_W   = 8;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic signed [ELEV_W-1:0] THR_RESET = ELEV_W'(1000);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } top_state_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } sel_state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } sel_req_t;

  typedef struct packed {
    logic             done;
    logic [SIG_W-1:0] median;
  } sel_rsp_t;

  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] c);
    sat_inc = (c == TALLY_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ===== hdl/ssm_ifs.sv =====
// Valid/ready channel interfaces: satellite records in, snapshot summary out.
// Depends on ssm_pkg for field widths.
`timescale 1ns / 1ps
interface ssm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  carries_satellite;
  logic                                  position_known;
  logic                                  in_use;
  logic signed [ssm_pkg::SNR_W-1:0]      signal_strength;
  logic signed [ssm_pkg::ELEV_W-1:0]     elevation;
  logic                                  last;

  modport source (output valid, carries_satellite, position_known, in_use,
                  signal_strength, elevation, last, input ready);
  modport sink   (input valid, carries_satellite, position_known, in_use,
                  signal_strength, elevation, last, output ready);
endinterface

interface ssm_out_if;
  logic                           valid;
  logic                           ready;
  logic [ssm_pkg::TALLY_W-1:0]    visible_count;
  logic [ssm_pkg::TALLY_W-1:0]    used_count;
  logic [ssm_pkg::TALLY_W-1:0]    low_used_count;
  logic [ssm_pkg::SIG_W-1:0]      median_signal;

  modport source (output valid, visible_count, used_count, low_used_count,
                  median_signal, input ready);
  modport sink   (input valid, visible_count, used_count, low_used_count,
                  median_signal, output ready);
endinterface

// ===== hdl/ssm_sig_ram.sv =====
// Signal strength store: one write port, one read port, registered read data.
// Depends on ssm_pkg for depth and width.
`timescale 1ns / 1ps
module ssm_sig_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ssm_pkg::IDX_W-1:0]   waddr_i,
  input  logic [ssm_pkg::SIG_W-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [ssm_pkg::IDX_W-1:0]   raddr_i,
  output logic [ssm_pkg::SIG_W-1:0]   rdata_o
);

  logic [ssm_pkg::SIG_W-1:0] mem [ssm_pkg::MAX_SAT];
  logic [ssm_pkg::SIG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ssm_select.sv =====
// Radix selection engine: finds the two middle ranks of the stored signals,
// one bit per pass over the store. Depends on ssm_pkg; reads ssm_sig_ram.
`timescale 1ns / 1ps
module ssm_select (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssm_pkg::sel_req_t           req_i,
  output ssm_pkg::sel_rsp_t           rsp_o,
  output logic                        rd_en_o,
  output logic [ssm_pkg::IDX_W-1:0]   rd_addr_o,
  input  logic [ssm_pkg::SIG_W-1:0]   rd_data_i
);

  ssm_pkg::sel_state_e state_q, state_d;
  logic rvld_q, done_q;

  logic [ssm_pkg::CNT_W-1:0] n_q, addr_q, ka_q, kb_q, ca_q, cb_q;
  logic [ssm_pkg::SIG_W-1:0] pref_a_q, pref_b_q, med_q;
  logic [ssm_pkg::BIT_W-1:0] bit_q;

  logic [ssm_pkg::SIG_W:0]   hi_mask_w, med_sum;
  logic [ssm_pkg::SIG_W-1:0] hi_mask, bit_oh, fin_a, fin_b, median;
  logic match_a, match_b, take_a, take_b, pass_end, scanning;

  always_comb begin
    hi_mask_w = {(ssm_pkg::SIG_W + 1){1'b1}} << ({1'b0, bit_q} + 1'b1);
    hi_mask   = hi_mask_w[ssm_pkg::SIG_W-1:0];
    bit_oh    = ssm_pkg::SIG_W'(1) << bit_q;
    match_a   = (((rd_data_i ^ pref_a_q) & hi_mask) == '0) && !rd_data_i[bit_q];
    match_b   = (((rd_data_i ^ pref_b_q) & hi_mask) == '0) && !rd_data_i[bit_q];
    take_a    = ka_q >= ca_q;
    take_b    = kb_q >= cb_q;
    fin_a     = take_a ? (pref_a_q | bit_oh) : pref_a_q;
    fin_b     = take_b ? (pref_b_q | bit_oh) : pref_b_q;
    med_sum   = {1'b0, fin_a} + {1'b0, fin_b};
    median    = med_sum[ssm_pkg::SIG_W:1];
    scanning  = (state_q == ssm_pkg::S_SCAN);
    rd_en_o   = scanning && (addr_q < n_q);
    pass_end  = scanning && (addr_q == n_q) && !rvld_q;
  end

  assign rd_addr_o = addr_q[ssm_pkg::IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssm_pkg::S_IDLE: if (req_i.start) state_d = ssm_pkg::S_SCAN;
      ssm_pkg::S_SCAN: if (pass_end && bit_q == '0) state_d = ssm_pkg::S_IDLE;
      default:         state_d = ssm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssm_pkg::S_IDLE;
      rvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rd_en_o;
      done_q  <= pass_end && (bit_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ssm_pkg::S_IDLE && req_i.start) begin
      n_q      <= req_i.n;
      ka_q     <= (req_i.n - 1'b1) >> 1;
      kb_q     <= req_i.n >> 1;
      pref_a_q <= '0;
      pref_b_q <= '0;
      bit_q    <= ssm_pkg::BIT_W'(ssm_pkg::SIG_W - 1);
      addr_q   <= '0;
      ca_q     <= '0;
      cb_q     <= '0;
    end else if (scanning) begin
      if (pass_end) begin
        pref_a_q <= fin_a;
        pref_b_q <= fin_b;
        ka_q     <= take_a ? ka_q - ca_q : ka_q;
        kb_q     <= take_b ? kb_q - cb_q : kb_q;
        ca_q     <= '0;
        cb_q     <= '0;
        addr_q   <= '0;
        if (bit_q == '0) begin
          med_q <= median;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end else begin
        if (rd_en_o) addr_q <= addr_q + 1'b1;
        if (rvld_q) begin
          ca_q <= ca_q + ssm_pkg::CNT_W'(match_a);
          cb_q <= cb_q + ssm_pkg::CNT_W'(match_b);
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.median = med_q;

endmodule

// ===== hdl/satellite_set_summary_median_top.sv =====
// Top level of the satellite set summary: counters, control, output register.
// Depends on ssm_pkg, ssm_ifs, ssm_sig_ram and ssm_select.
`timescale 1ns / 1ps
// Usage:
//   sat_i takes one satellite record per transfer; last closes the snapshot.
//   sum_o gives one summary per snapshot: three counts and the median signal.
//   cfg_we_i/cfg_wdata_i write the signed low elevation threshold (reset
//   1000); write it only while no snapshot is being summarised.
// Flow:
//   A record without last is taken whenever the block is idle. A record
//   with last also starts the median search, then the summary is loaded
//   into the output register. The search is a radix selection over the
//   signal store, one bit per pass, seven passes; each pass reads the n
//   stored signals (at most 64) through the single read port of the store.
//   With no stored signals the search is skipped.
// Reset:
//   Counters clear and the threshold returns to 1000; the store needs no
//   clearing since only written entries are read.
// Receiver stall:
//   The summary waits in the output register; new records are still taken
//   until the next snapshot's summary needs that register.
module satellite_set_summary_median_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [ssm_pkg::ELEV_W-1:0]   cfg_wdata_i,
  ssm_in_if.sink                              sat_i,
  ssm_out_if.source                           sum_o
);

  ssm_pkg::top_state_e state_q, state_d;

  logic signed [ssm_pkg::ELEV_W-1:0] thr_q;
  logic [ssm_pkg::TALLY_W-1:0] vis_q, vis_d, used_q, used_d, low_q, low_d;
  logic [ssm_pkg::CNT_W-1:0]   scnt_q, scnt_d;
  logic [ssm_pkg::SIG_W-1:0]   med_q;
  logic out_vld_q;
  logic [ssm_pkg::TALLY_W-1:0] out_vis_q, out_used_q, out_low_q;
  logic [ssm_pkg::SIG_W-1:0]   out_med_q;

  logic acc, seen, used, store, load;
  ssm_pkg::sel_req_t sel_req;
  ssm_pkg::sel_rsp_t sel_rsp;
  logic rd_en;
  logic [ssm_pkg::IDX_W-1:0] rd_addr;
  logic [ssm_pkg::SIG_W-1:0] rd_data;

  assign sat_i.ready = (state_q == ssm_pkg::T_IDLE);
  assign acc  = sat_i.valid && sat_i.ready;
  assign seen = sat_i.carries_satellite && sat_i.position_known;
  assign used = seen && sat_i.in_use;
  assign store = acc && used && !sat_i.signal_strength[ssm_pkg::SNR_W-1] &&
                 (sat_i.signal_strength != '0) &&
                 (scnt_q < ssm_pkg::CNT_W'(ssm_pkg::MAX_SAT));
  assign load = (state_q == ssm_pkg::T_HOLD) && (!out_vld_q || sum_o.ready);

  always_comb begin
    vis_d  = vis_q;
    used_d = used_q;
    low_d  = low_q;
    scnt_d = scnt_q;
    if (load) begin
      vis_d  = '0;
      used_d = '0;
      low_d  = '0;
      scnt_d = '0;
    end else if (acc) begin
      if (seen) vis_d = ssm_pkg::sat_inc(vis_q);
      if (used) begin
        used_d = ssm_pkg::sat_inc(used_q);
        if (sat_i.elevation < thr_q) low_d = ssm_pkg::sat_inc(low_q);
      end
      if (store) scnt_d = scnt_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssm_pkg::T_IDLE: begin
        if (acc && sat_i.last) begin
          state_d = (scnt_d == '0) ? ssm_pkg::T_HOLD : ssm_pkg::T_BUSY;
        end
      end
      ssm_pkg::T_BUSY: if (sel_rsp.done) state_d = ssm_pkg::T_HOLD;
      ssm_pkg::T_HOLD: if (load) state_d = ssm_pkg::T_IDLE;
      default:         state_d = ssm_pkg::T_IDLE;
    endcase
  end

  assign sel_req.start = acc && sat_i.last && (scnt_d != '0);
  assign sel_req.n     = scnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ssm_pkg::T_IDLE;
      thr_q     <= ssm_pkg::THR_RESET;
      vis_q     <= '0;
      used_q    <= '0;
      low_q     <= '0;
      scnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      vis_q   <= vis_d;
      used_q  <= used_d;
      low_q   <= low_d;
      scnt_q  <= scnt_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (sum_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && sat_i.last && scnt_d == '0) begin
      med_q <= '0;
    end else if (sel_rsp.done) begin
      med_q <= sel_rsp.median;
    end
    if (load) begin
      out_vis_q  <= vis_q;
      out_used_q <= used_q;
      out_low_q  <= low_q;
      out_med_q  <= med_q;
    end
  end

  assign sum_o.valid          = out_vld_q;
  assign sum_o.visible_count  = out_vis_q;
  assign sum_o.used_count     = out_used_q;
  assign sum_o.low_used_count = out_low_q;
  assign sum_o.median_signal  = out_med_q;

  ssm_sig_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (scnt_q[ssm_pkg::IDX_W-1:0]),
    .wdata_i (sat_i.signal_strength[ssm_pkg::SIG_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ssm_select u_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sel_req),
    .rsp_o     (sel_rsp),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_rsp.done |-> state_q == ssm_pkg::T_BUSY)
    else $error("selection finished outside a search");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= ssm_pkg::CNT_W'(ssm_pkg::MAX_SAT))
    else $error("signal count beyond store depth");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && sat_i.last) |=> !sat_i.ready)
    else $error("record taken while summary pending");

  a_no_used_zero_med: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_o.valid && sum_o.used_count == '0) |-> sum_o.median_signal == '0)
    else $error("median without used satellites");

endmodule
